/* rtl/g24sd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package g24sd_pkg;

   localparam int HALF_W = 12;
   localparam int WORD_W = 2 * HALF_W;
   localparam int WT_W   = 4;

   typedef logic [HALF_W-1:0] half_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [WT_W-1:0]   weight_type;

   typedef struct packed {
      word_type corrected_word;
      logic     decode_failure;
   } result_type;

   // Rows of the generator side matrix B (bit k of a row is column k)
   localparam half_type GOLAY_B [HALF_W] = '{
      12'hB71, 12'hDB8, 12'hADC, 12'h96E, 12'h8B7, 12'hC5B,
      12'hE2D, 12'hF16, 12'hB8B, 12'hDC5, 12'hEE2, 12'h7FF
   };

   // Hamming weight of a half word
   function automatic weight_type bit_weight(input half_type v);
      weight_type n;
      n = '0;
      for (int k = 0; k < HALF_W; k++) begin
         n = n + weight_type'(v[k]);
      end
      return n;
   endfunction

   // v times B: XOR of the rows picked by the set bits of v
   function automatic half_type times_b(input half_type v);
      half_type acc;
      acc = '0;
      for (int k = 0; k < HALF_W; k++) begin
         if (v[k]) begin
            acc = acc ^ GOLAY_B[k];
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

/* rtl/g24sd_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface g24sd_req_if
   import g24sd_pkg::*;
();
   logic     valid;
   logic     ready;
   word_type received_word;

   modport source (output valid, output received_word, input ready);
   modport sink   (input valid, input received_word, output ready);
endinterface

`default_nettype wire

/* rtl/g24sd_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface g24sd_rsp_if
   import g24sd_pkg::*;
();
   logic     valid;
   logic     ready;
   word_type corrected_word;
   logic     decode_failure;

   modport source (output valid, output corrected_word, output decode_failure, input ready);
   modport sink   (input valid, input corrected_word, input decode_failure, output ready);
endinterface

`default_nettype wire

/* rtl/golay24_syndrome_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                  Handshake
// req_if    in   received_word[23:0]                      valid/ready
// rsp_if    out  corrected_word[23:0], decode_failure     valid/ready
//
// One request per cycle when not stalled; it passes the request register, then the result register.
// The syndrome, the weight checks and the correction sit between the request
// register and the result register in one pass of logic.
// Reset clears both valid flags; the payload registers keep what they hold.
// A stalled result holds its register; the request stage still fills behind it.

module golay24_syndrome_decoder
   import g24sd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   g24sd_req_if.sink  req_if,
   g24sd_rsp_if.source rsp_if
);

   logic       in_valid_ff;
   logic       in_valid_in;
   word_type   word_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type result_ff;
   result_type decoded;
   logic       out_free;

   // Result register frees when empty or taken this cycle
   assign out_free      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready  = !in_valid_ff || out_free;

   assign in_valid_in   = req_if.ready ? req_if.valid : in_valid_ff;
   assign out_valid_in  = out_free ? in_valid_ff : out_valid_ff;

   // Capture request word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_if.valid && req_if.ready) begin
         word_ff <= req_if.received_word;
      end
   end

   g24sd_decode u_decode (
      .word   (word_ff),
      .result (decoded)
   );

   // Advance decoded word into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (out_free && in_valid_ff) begin
         result_ff <= decoded;
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.corrected_word = result_ff.corrected_word;
   assign rsp_if.decode_failure = result_ff.decode_failure;

endmodule

`default_nettype wire

/* rtl/g24sd_decode.sv */
`timescale 1ns / 1ps
`default_nettype none

module g24sd_decode
   import g24sd_pkg::*;
(
   input  word_type   word,
   output result_type result
);

   half_type   syn;
   half_type   syn_b;
   half_type   err_left;
   half_type   err_right;
   half_type   diff;
   weight_type wt_syn;
   weight_type wt_syn_b;
   logic       found;

   // Form syndrome and its image under B
   assign syn      = word[HALF_W-1:0] ^ times_b(word[WORD_W-1:HALF_W]);
   assign syn_b    = times_b(syn);
   assign wt_syn   = bit_weight(syn);
   assign wt_syn_b = bit_weight(syn_b);

   // Try the four rules in order; lowest row wins within a rule
   always_comb begin
      found     = 1'b0;
      err_left  = '0;
      err_right = '0;
      diff      = '0;
      if (wt_syn <= weight_type'(3)) begin
         err_left = syn;
         found    = 1'b1;
      end
      for (int i = 0; i < HALF_W; i++) begin
         diff = syn ^ GOLAY_B[i];
         if (!found && bit_weight(diff) <= weight_type'(2)) begin
            err_left  = diff;
            err_right = half_type'(1) << i;
            found     = 1'b1;
         end
      end
      if (!found && (wt_syn_b == weight_type'(2) || wt_syn_b == weight_type'(3))) begin
         err_right = syn_b;
         found     = 1'b1;
      end
      for (int i = 0; i < HALF_W; i++) begin
         diff = syn_b ^ GOLAY_B[i];
         if (!found && bit_weight(diff) == weight_type'(2)) begin
            err_left  = half_type'(1) << i;
            err_right = diff;
            found     = 1'b1;
         end
      end
   end

   // Apply the error pattern, or flag failure with a zero word
   always_comb begin
      if (found) begin
         result.corrected_word = word ^ {err_right, err_left};
         result.decode_failure = 1'b0;
      end else begin
         result.corrected_word = '0;
         result.decode_failure = 1'b1;
      end
   end

endmodule

`default_nettype wire
